// ===== rtl/fmbq_pkg.sv =====
`default_nettype none

package fmbq_pkg;

    // queue geometry
    localparam int DEPTH    = 1024;
    localparam int VALUE_W  = 30;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int SUM_W    = CNT_W + 1;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT  = FUNC_W'(0);
    localparam logic [FUNC_W-1:0] FUNC_PUSH_MIDDLE = FUNC_W'(1);
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK   = FUNC_W'(2);
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT   = FUNC_W'(3);
    localparam logic [FUNC_W-1:0] FUNC_POP_MIDDLE  = FUNC_W'(4);
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK    = FUNC_W'(5);

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // write data: the pushed value, or what was read from the other half
    typedef enum logic {
        WSRC_VALUE,
        WSRC_CROSS
    } wsrc_t;

    typedef enum logic [1:0] {
        POP_NONE,
        POP_FRONT_HALF,
        POP_BACK_HALF
    } pop_src_t;

    // heads and counts of both halves
    typedef struct packed {
        logic [ADDR_W-1:0] fh;
        logic [CNT_W-1:0]  fc;
        logic [ADDR_W-1:0] bh;
        logic [CNT_W-1:0]  bc;
    } ptr_t;

    // memory accesses and result routing for one item
    typedef struct packed {
        logic              f_rd_en;
        logic [ADDR_W-1:0] f_rd_addr;
        logic              f_wr_en;
        logic [ADDR_W-1:0] f_wr_addr;
        wsrc_t             f_wr_src;
        logic              b_rd_en;
        logic [ADDR_W-1:0] b_rd_addr;
        logic              b_wr_en;
        logic [ADDR_W-1:0] b_wr_addr;
        wsrc_t             b_wr_src;
        pop_src_t          pop_src;
        status_t           status;
    } plan_t;

    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0]  offs);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(offs);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] base);
        return (base == ADDR_W'(DEPTH - 1)) ? '0 : base + ADDR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] wrap_dec(input logic [ADDR_W-1:0] base);
        return (base == '0) ? ADDR_W'(DEPTH - 1) : base - ADDR_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fmbq_plan.sv =====
`default_nettype none

module fmbq_plan (
    input  logic [fmbq_pkg::FUNC_W-1:0] func,
    input  fmbq_pkg::ptr_t              ptr,
    output fmbq_pkg::plan_t             plan,
    output fmbq_pkg::ptr_t              ptr_next
);
    import fmbq_pkg::*;

    logic [SUM_W-1:0]  total;
    logic              full;
    logic              empty;
    logic              f_long;
    logic [CNT_W-1:0]  fc_m1;
    logic [CNT_W-1:0]  bc_m1;
    logic [ADDR_W-1:0] f_last;
    logic [ADDR_W-1:0] f_end;
    logic [ADDR_W-1:0] b_last;
    logic [ADDR_W-1:0] b_end;

    assign total  = SUM_W'(ptr.fc) + SUM_W'(ptr.bc);
    assign full   = (total >= SUM_W'(DEPTH));
    assign empty  = (ptr.fc == '0);
    // front half one longer than the back half
    assign f_long = (ptr.fc != ptr.bc);
    assign fc_m1  = ptr.fc - CNT_W'(1);
    assign bc_m1  = ptr.bc - CNT_W'(1);
    assign f_last = wrap_add(ptr.fh, fc_m1);
    assign f_end  = wrap_add(ptr.fh, ptr.fc);
    assign b_last = wrap_add(ptr.bh, bc_m1);
    assign b_end  = wrap_add(ptr.bh, ptr.bc);

    always_comb
    begin
        // all-zero plan: no access, ok status, nothing popped
        plan     = '0;
        ptr_next = ptr;
        case (func)
            FUNC_PUSH_FRONT:
            begin
                if (full)
                begin
                    plan.status = STATUS_FULL;
                end
                else
                begin
                    plan.f_wr_en   = 1'b1;
                    plan.f_wr_addr = wrap_dec(ptr.fh);
                    plan.f_wr_src  = WSRC_VALUE;
                    ptr_next.fh    = wrap_dec(ptr.fh);
                    ptr_next.fc    = ptr.fc + CNT_W'(1);
                    if (f_long)
                    begin
                        // last of front half moves to head of back half
                        plan.f_rd_en   = 1'b1;
                        plan.f_rd_addr = f_last;
                        plan.b_wr_en   = 1'b1;
                        plan.b_wr_addr = wrap_dec(ptr.bh);
                        plan.b_wr_src  = WSRC_CROSS;
                        ptr_next.bh    = wrap_dec(ptr.bh);
                        ptr_next.bc    = ptr.bc + CNT_W'(1);
                        ptr_next.fc    = ptr.fc;
                    end
                end
            end
            FUNC_PUSH_MIDDLE:
            begin
                if (full)
                begin
                    plan.status = STATUS_FULL;
                end
                else if (f_long)
                begin
                    // old last moves across, new value takes its slot
                    plan.f_rd_en   = 1'b1;
                    plan.f_rd_addr = f_last;
                    plan.b_wr_en   = 1'b1;
                    plan.b_wr_addr = wrap_dec(ptr.bh);
                    plan.b_wr_src  = WSRC_CROSS;
                    plan.f_wr_en   = 1'b1;
                    plan.f_wr_addr = f_last;
                    plan.f_wr_src  = WSRC_VALUE;
                    ptr_next.bh    = wrap_dec(ptr.bh);
                    ptr_next.bc    = ptr.bc + CNT_W'(1);
                end
                else
                begin
                    plan.f_wr_en   = 1'b1;
                    plan.f_wr_addr = f_end;
                    plan.f_wr_src  = WSRC_VALUE;
                    ptr_next.fc    = ptr.fc + CNT_W'(1);
                end
            end
            FUNC_PUSH_BACK:
            begin
                if (full)
                begin
                    plan.status = STATUS_FULL;
                end
                else
                begin
                    plan.b_wr_en   = 1'b1;
                    plan.b_wr_addr = b_end;
                    plan.b_wr_src  = WSRC_VALUE;
                    ptr_next.bc    = ptr.bc + CNT_W'(1);
                    if (!f_long)
                    begin
                        // head of back half moves to end of front half;
                        // with an empty back half that is the new value itself
                        plan.f_wr_en   = 1'b1;
                        plan.f_wr_addr = f_end;
                        plan.f_wr_src  = (ptr.bc == '0) ? WSRC_VALUE : WSRC_CROSS;
                        plan.b_rd_en   = (ptr.bc != '0);
                        plan.b_rd_addr = ptr.bh;
                        ptr_next.bh    = wrap_inc(ptr.bh);
                        ptr_next.bc    = ptr.bc;
                        ptr_next.fc    = ptr.fc + CNT_W'(1);
                    end
                end
            end
            FUNC_POP_FRONT:
            begin
                if (empty)
                begin
                    plan.status = STATUS_EMPTY;
                end
                else
                begin
                    plan.f_rd_en   = 1'b1;
                    plan.f_rd_addr = ptr.fh;
                    plan.pop_src   = POP_FRONT_HALF;
                    ptr_next.fh    = wrap_inc(ptr.fh);
                    ptr_next.fc    = fc_m1;
                    if (!f_long)
                    begin
                        plan.b_rd_en   = 1'b1;
                        plan.b_rd_addr = ptr.bh;
                        plan.f_wr_en   = 1'b1;
                        plan.f_wr_addr = f_end;
                        plan.f_wr_src  = WSRC_CROSS;
                        ptr_next.bh    = wrap_inc(ptr.bh);
                        ptr_next.bc    = bc_m1;
                        ptr_next.fc    = ptr.fc;
                    end
                end
            end
            FUNC_POP_MIDDLE:
            begin
                if (empty)
                begin
                    plan.status = STATUS_EMPTY;
                end
                else
                begin
                    plan.f_rd_en   = 1'b1;
                    plan.f_rd_addr = f_last;
                    plan.pop_src   = POP_FRONT_HALF;
                    ptr_next.fc    = fc_m1;
                    if (!f_long)
                    begin
                        // refill the vacated slot from head of back half
                        plan.b_rd_en   = 1'b1;
                        plan.b_rd_addr = ptr.bh;
                        plan.f_wr_en   = 1'b1;
                        plan.f_wr_addr = f_last;
                        plan.f_wr_src  = WSRC_CROSS;
                        ptr_next.bh    = wrap_inc(ptr.bh);
                        ptr_next.bc    = bc_m1;
                        ptr_next.fc    = ptr.fc;
                    end
                end
            end
            FUNC_POP_BACK:
            begin
                if (empty)
                begin
                    plan.status = STATUS_EMPTY;
                end
                else if (ptr.bc == '0)
                begin
                    // single item sits in the front half
                    plan.f_rd_en   = 1'b1;
                    plan.f_rd_addr = f_last;
                    plan.pop_src   = POP_FRONT_HALF;
                    ptr_next.fc    = fc_m1;
                end
                else
                begin
                    plan.b_rd_en   = 1'b1;
                    plan.b_rd_addr = b_last;
                    plan.pop_src   = POP_BACK_HALF;
                    ptr_next.bc    = bc_m1;
                    if (f_long)
                    begin
                        plan.f_rd_en   = 1'b1;
                        plan.f_rd_addr = f_last;
                        plan.b_wr_en   = 1'b1;
                        plan.b_wr_addr = wrap_dec(ptr.bh);
                        plan.b_wr_src  = WSRC_CROSS;
                        ptr_next.bh    = wrap_dec(ptr.bh);
                        ptr_next.bc    = ptr.bc;
                        ptr_next.fc    = fc_m1;
                    end
                end
            end
            default:
            begin
                plan.status = STATUS_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/front_middle_back_queue.sv =====
// order: memory read as an item is accepted, memory write and result register as it
// leaves the second stage, which waits while the result register is stalled
// throughput: one item per cycle while out_stall is low; each half's registered read
// feeds the rebalance write on leaving s2, with forwarding between neighbouring items
// reset: rst_n asynchronous active low clears heads, counts and all valid flags;
// the two half stores are not cleared, entries are only read after being written
`default_nettype none

module front_middle_back_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fmbq_pkg::FUNC_W-1:0]   func,
    input  logic [fmbq_pkg::VALUE_W-1:0]  value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fmbq_pkg::VALUE_W-1:0]  popped_value,
    output logic [fmbq_pkg::STATUS_W-1:0] status,
    output logic [fmbq_pkg::CNT_W-1:0]    occupancy
);
    import fmbq_pkg::*;

    // the two half queues, each a circular buffer
    logic [VALUE_W-1:0] f_mem [DEPTH];
    logic [VALUE_W-1:0] b_mem [DEPTH];
    logic [VALUE_W-1:0] f_q_reg;
    logic [VALUE_W-1:0] b_q_reg;

    // heads and counts, updated as soon as an item is accepted
    ptr_t ptr_reg;
    ptr_t ptr_next;
    plan_t plan;

    // second stage: item whose reads are done and whose writes are pending
    logic               s2_valid_reg;
    plan_t              s2_plan_reg;
    logic [VALUE_W-1:0] s2_value_reg;
    logic [CNT_W-1:0]   s2_occ_reg;

    // forwarding of the previous item's write to this item's read
    logic               f_fwd_reg;
    logic               b_fwd_reg;
    logic [VALUE_W-1:0] f_fwd_data_reg;
    logic [VALUE_W-1:0] b_fwd_data_reg;

    // result register
    logic               out_valid_reg;
    logic [VALUE_W-1:0] popped_value_reg;
    status_t            status_reg;
    logic [CNT_W-1:0]   occupancy_reg;

    logic               out_free;
    logic               s2_move;
    logic               accept;
    logic [VALUE_W-1:0] fq;
    logic [VALUE_W-1:0] bq;
    logic [VALUE_W-1:0] f_wr_data;
    logic [VALUE_W-1:0] b_wr_data;
    logic [VALUE_W-1:0] popped;
    logic               f_we;
    logic               b_we;

    fmbq_plan u_plan (
        .func     (func),
        .ptr      (ptr_reg),
        .plan     (plan),
        .ptr_next (ptr_next)
    );

    // handshake: the result register frees the second stage, which frees the input
    assign out_free = !out_valid_reg || !out_stall;
    assign s2_move  = s2_valid_reg && out_free;
    assign in_stall = s2_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    // read data, corrected for a write made at the same edge as the read
    assign fq = f_fwd_reg ? f_fwd_data_reg : f_q_reg;
    assign bq = b_fwd_reg ? b_fwd_data_reg : b_q_reg;

    // a crossing move writes one half with the item just read from the other
    assign f_wr_data = (s2_plan_reg.f_wr_src == WSRC_VALUE) ? s2_value_reg : bq;
    assign b_wr_data = (s2_plan_reg.b_wr_src == WSRC_VALUE) ? s2_value_reg : fq;
    assign f_we      = s2_move && s2_plan_reg.f_wr_en;
    assign b_we      = s2_move && s2_plan_reg.b_wr_en;

    always_comb
    begin
        case (s2_plan_reg.pop_src)
            POP_FRONT_HALF: popped = fq;
            POP_BACK_HALF:  popped = bq;
            default:        popped = '0;
        endcase
    end

    // front half store
    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            f_mem[s2_plan_reg.f_wr_addr] <= f_wr_data;
        end
        if (accept && plan.f_rd_en)
        begin
            f_q_reg <= f_mem[plan.f_rd_addr];
        end
    end

    // back half store
    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[s2_plan_reg.b_wr_addr] <= b_wr_data;
        end
        if (accept && plan.b_rd_en)
        begin
            b_q_reg <= b_mem[plan.b_rd_addr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            s2_valid_reg  <= 1'b0;
            f_fwd_reg     <= 1'b0;
            b_fwd_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ptr_reg      <= ptr_next;
                s2_valid_reg <= 1'b1;
                // the memory returns old data when the same entry is written now
                f_fwd_reg    <= f_we && plan.f_rd_en
                                && (plan.f_rd_addr == s2_plan_reg.f_wr_addr);
                b_fwd_reg    <= b_we && plan.b_rd_en
                                && (plan.b_rd_addr == s2_plan_reg.b_wr_addr);
            end
            else if (s2_move)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_plan_reg    <= plan;
            s2_value_reg   <= value;
            s2_occ_reg     <= ptr_next.fc + ptr_next.bc;
            f_fwd_data_reg <= f_wr_data;
            b_fwd_data_reg <= b_wr_data;
        end
        if (s2_move)
        begin
            popped_value_reg <= popped;
            status_reg       <= s2_plan_reg.status;
            occupancy_reg    <= s2_occ_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_value_reg;
    assign status       = status_reg;
    assign occupancy    = occupancy_reg;

    // the halves stay balanced: front equal to back or one longer
    assert property (@(posedge clk) disable iff (!rst_n)
        (ptr_reg.fc == ptr_reg.bc) || (ptr_reg.fc == ptr_reg.bc + CNT_W'(1)))
        else $error("half queues out of balance");

    // never more items held than the store can take
    assert property (@(posedge clk) disable iff (!rst_n)
        (SUM_W'(ptr_reg.fc) + SUM_W'(ptr_reg.bc)) <= SUM_W'(DEPTH))
        else $error("occupancy beyond depth");

    // a refused push reports a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_FULL)) |-> (occupancy == CNT_W'(DEPTH)))
        else $error("full status with room left");

    // a refused pop reports an empty queue and no value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_EMPTY)) |-> ((occupancy == '0) && (popped_value == '0)))
        else $error("empty status with items held");

endmodule

`default_nettype wire
